// File: rtl/core/lprl_pkg.sv
// shared types and constants for the longest prefix route lookup core
package lprl_pkg;

  localparam int ADDR_W      = 32;
  localparam int PORT_FLD_W  = 4;
  localparam int LEN_W       = 11;
  localparam int IDX_FLD_W   = 10;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic clear;
    logic valid;
  } scan_ctl_t;

endpackage

// File: rtl/core/lprl_ram.sv
// generic simple dual port ram with registered read
module lprl_ram #(
  parameter int WIDTH = 100,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/lprl_scan.sv
// match and best-route tracking over entries streamed out of the table
module lprl_scan
  import lprl_pkg::*;
#(
  parameter int PORT_BITS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  scan_ctl_t            ctl,
  input  logic [ADDR_W-1:0]    dest,
  input  logic [ADDR_W-1:0]    ent_prefix,
  input  logic [ADDR_W-1:0]    ent_mask,
  input  logic [ADDR_W-1:0]    ent_hop,
  input  logic [PORT_BITS-1:0] ent_port,
  output logic                 have,
  output logic [ADDR_W-1:0]    best_mask,
  output logic [ADDR_W-1:0]    best_hop,
  output logic [PORT_BITS-1:0] best_port
);

  logic                 have_r;
  logic [ADDR_W-1:0]    best_mask_r;
  logic [ADDR_W-1:0]    best_hop_r;
  logic [PORT_BITS-1:0] best_port_r;
  logic                 take;

  // strict greater keeps the lowest index on equal masks
  assign take = ctl.valid && ((dest & ent_mask) == ent_prefix) &&
                (!have_r || (ent_mask > best_mask_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (ctl.clear) begin
      have_r <= 1'b0;
    end else if (take) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_mask_r <= ent_mask;
      best_hop_r  <= ent_hop;
      best_port_r <= ent_port;
    end
  end

  assign have      = have_r;
  assign best_mask = best_mask_r;
  assign best_hop  = best_hop_r;
  assign best_port = best_port_r;

endmodule

// File: rtl/core/longest_prefix_route_lookup_core.sv
// IPv4 longest prefix match route table: load items write one entry, lookup items scan
// the first table_len entries, one entry per cycle through the single table read port.
// A table_len above TABLE_ENTRIES scans the whole table. A load raises no busy and gives
// no result. A lookup holds busy until every scanned entry has been read and scored, and
// then gives its result on out_valid for exactly one cycle; the receiver cannot stall, so the
// result must be captured then.
// Entries are undefined until loaded and no lookup may scan an entry never written.
module longest_prefix_route_lookup_core
  import lprl_pkg::*;
#(
  parameter int TABLE_ENTRIES = 1024,
  parameter int PORT_BITS     = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_cmd,
  input  logic [IDX_FLD_W-1:0]  in_entry_index,
  input  logic [ADDR_W-1:0]     in_route_prefix_in,
  input  logic [ADDR_W-1:0]     in_route_mask_in,
  input  logic [ADDR_W-1:0]     in_gateway_in,
  input  logic [PORT_FLD_W-1:0] in_port_in,
  input  logic [ADDR_W-1:0]     in_dest_ip,
  output logic                  out_valid,
  output logic                  out_found,
  output logic [ADDR_W-1:0]     out_gateway_out,
  output logic [PORT_FLD_W-1:0] out_port_out,
  output logic [ADDR_W-1:0]     out_matched_mask,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [LEN_W-1:0]      cfg_table_len
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int WORD_W = 3 * ADDR_W + PORT_BITS;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t                state_r;
  logic [LEN_W-1:0]      table_len_r;
  logic [ADDR_W-1:0]     dest_r;
  logic [CNT_W-1:0]      limit_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  pend_r;
  logic                  out_valid_r;
  logic                  out_found_r;
  logic [ADDR_W-1:0]     out_hop_r;
  logic [PORT_FLD_W-1:0] out_port_r;
  logic [ADDR_W-1:0]     out_mask_r;

  logic                  accept;
  logic                  wr_en;
  logic [31:0]           idx_ext;
  logic [31:0]           len_ext;
  logic [31:0]           limit_ext;
  logic [7:0]            port_in_ext;
  logic [WORD_W-1:0]     wr_word;
  logic [WORD_W-1:0]     rd_word;
  logic                  rd_en;
  logic                  scan_done;
  scan_ctl_t             scan_ctl;

  logic                  have;
  logic [ADDR_W-1:0]     best_mask;
  logic [ADDR_W-1:0]     best_hop;
  logic [PORT_BITS-1:0]  best_port;
  logic [7:0]            best_port_ext;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // loads beyond the table are dropped
  assign idx_ext     = 32'(in_entry_index);
  assign wr_en       = accept && (in_cmd == CMD_LOAD) && (idx_ext < 32'(TABLE_ENTRIES));
  assign port_in_ext = 8'(in_port_in);
  assign wr_word     = {in_route_prefix_in, in_route_mask_in, in_gateway_in,
                        port_in_ext[PORT_BITS-1:0]};

  assign len_ext   = 32'(table_len_r);
  assign limit_ext = (len_ext > 32'(TABLE_ENTRIES)) ? 32'(TABLE_ENTRIES) : len_ext;

  assign rd_en     = (state_r == ST_SCAN) && (cnt_r < limit_r);
  assign scan_done = (state_r == ST_SCAN) && (cnt_r == limit_r) && !pend_r;

  assign scan_ctl.clear = accept && (in_cmd == CMD_LOOKUP);
  assign scan_ctl.valid = pend_r;

  lprl_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(idx_ext[IDX_W-1:0]),
    .wdata(wr_word),
    .re   (rd_en),
    .raddr(cnt_r[IDX_W-1:0]),
    .rdata(rd_word)
  );

  lprl_scan #(
    .PORT_BITS(PORT_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .dest      (dest_r),
    .ent_prefix(rd_word[WORD_W-1 -: ADDR_W]),
    .ent_mask  (rd_word[WORD_W-ADDR_W-1 -: ADDR_W]),
    .ent_hop   (rd_word[PORT_BITS+ADDR_W-1 -: ADDR_W]),
    .ent_port  (rd_word[PORT_BITS-1:0]),
    .have      (have),
    .best_mask (best_mask),
    .best_hop  (best_hop),
    .best_port (best_port)
  );

  assign best_port_ext = 8'(best_port);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_len_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      table_len_r <= cfg_table_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      pend_r      <= rd_en;
      case (state_r)
        ST_IDLE: begin
          if (accept && (in_cmd == CMD_LOOKUP)) begin
            dest_r  <= in_dest_ip;
            limit_r <= limit_ext[CNT_W-1:0];
            cnt_r   <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (scan_done) begin
            out_valid_r <= 1'b1;
            out_found_r <= have;
            out_hop_r   <= have ? best_hop : '0;
            out_port_r  <= have ? best_port_ext[PORT_FLD_W-1:0] : '0;
            out_mask_r  <= have ? best_mask : '0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_gateway_out  = out_hop_r;
  assign out_port_out     = out_port_r;
  assign out_matched_mask = out_mask_r;

endmodule
